>>> rtl/core/dheq_pkg.sv
package dheq_pkg;

	localparam int unsigned DEPTH_BINS = 65536;
	localparam int unsigned MAX_PIXELS = 1048576;

	localparam int unsigned ADDR_W  = $clog2(DEPTH_BINS);
	localparam int unsigned CNT_W   = $clog2(MAX_PIXELS + 1);
	localparam int unsigned NUM_W   = CNT_W + 8;
	localparam int unsigned DEPTH_W = 16;
	localparam int unsigned LEVEL_W = 8;

	localparam logic [ADDR_W-1:0] TOP_BIN = ADDR_W'(DEPTH_BINS - 1);
	localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_PIXELS);

	localparam logic REQ_COUNT = 1'b0;
	localparam logic REQ_MAP   = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic latch;      // capture the input item
		logic idx_clr;    // sweep index back to zero
		logic clr_wr;     // write zero at index, step index
		logic cnt_wr;     // write the incremented bin
		logic sw_start;   // start running sum at bin 1
		logic sw_rd;      // read bin at index
		logic sw_wr;      // write running sum, step index
		logic mul;        // numerator = bin * 255
		logic div_step;   // one quotient bit
		logic out_q;      // load quotient into output register
		logic out_zero;   // load level zero into output register
	} dheq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
		logic idx_last;
		logic zero_map;
		logic div_done;
		logic out_busy;
	} dheq_sts_t;

	// depth beyond the bins lands in the top bin
	function automatic logic [ADDR_W-1:0] bin_of(input logic [DEPTH_W-1:0] d);
		logic [ADDR_W-1:0] b;
		if (32'(d) >= DEPTH_BINS) begin
			b = TOP_BIN;
		end else begin
			b = ADDR_W'(d);
		end
		return b;
	endfunction

endpackage

>>> rtl/core/dheq_if.sv
interface dheq_in_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [dheq_pkg::DEPTH_W-1:0]  depth;
	logic                          last_pixel;

	modport source (output valid, req_type, depth, last_pixel, input ready);
	modport sink (input valid, req_type, depth, last_pixel, output ready);
endinterface

interface dheq_out_if;
	logic                          valid;
	logic                          ready;
	logic [dheq_pkg::LEVEL_W-1:0]  level;
	logic                          last_out;

	modport source (output valid, level, last_out, input ready);
	modport sink (input valid, level, last_out, output ready);
endinterface

>>> rtl/core/dheq_ram.sv
module dheq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/dheq_dp.sv
module dheq_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dheq_pkg::dheq_cmd_t          cmd,
	output dheq_pkg::dheq_sts_t          sts,
	input  logic [dheq_pkg::DEPTH_W-1:0] in_depth,
	input  logic                         in_last,
	dheq_out_if.source                   rsp
);

	logic                          last_q;
	logic [dheq_pkg::ADDR_W-1:0]   bin_q;
	logic [dheq_pkg::ADDR_W-1:0]   idx_q;
	logic [dheq_pkg::CNT_W-1:0]    prev_q;
	logic [dheq_pkg::CNT_W-1:0]    top_q;
	logic [dheq_pkg::NUM_W-1:0]    rem_q;
	logic [dheq_pkg::LEVEL_W-1:0]  quot_q;
	logic [2:0]                    k_q;
	logic                          ovalid_q;
	logic [dheq_pkg::LEVEL_W-1:0]  olevel_q;
	logic                          olast_q;

	logic                          we;
	logic [dheq_pkg::ADDR_W-1:0]   waddr;
	logic [dheq_pkg::CNT_W-1:0]    wdata;
	logic [dheq_pkg::ADDR_W-1:0]   raddr;
	logic [dheq_pkg::CNT_W-1:0]    rdata;
	logic [dheq_pkg::CNT_W:0]      inc_sum;
	logic [dheq_pkg::CNT_W-1:0]    inc_sat;
	logic [dheq_pkg::CNT_W:0]      acc_sum;
	logic [dheq_pkg::CNT_W-1:0]    acc_sat;
	logic [dheq_pkg::NUM_W-1:0]    dvs;
	logic                          fits;

	dheq_ram #(
		.WIDTH (dheq_pkg::CNT_W),
		.DEPTH (dheq_pkg::DEPTH_BINS)
	) u_bins (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// saturating increment and running sum
	always_comb begin
		inc_sum = {1'b0, rdata} + 1'b1;
		inc_sat = (inc_sum > {1'b0, dheq_pkg::CNT_MAX}) ? dheq_pkg::CNT_MAX
			: inc_sum[dheq_pkg::CNT_W-1:0];
		acc_sum = {1'b0, rdata} + {1'b0, prev_q};
		acc_sat = (acc_sum > {1'b0, dheq_pkg::CNT_MAX}) ? dheq_pkg::CNT_MAX
			: acc_sum[dheq_pkg::CNT_W-1:0];
	end

	// memory port selection
	always_comb begin
		raddr = cmd.sw_rd ? idx_q : bin_q;
		we    = cmd.clr_wr | cmd.cnt_wr | cmd.sw_wr;
		waddr = cmd.cnt_wr ? bin_q : idx_q;
		if (cmd.cnt_wr) begin
			wdata = inc_sat;
		end else if (cmd.sw_wr) begin
			wdata = acc_sat;
		end else begin
			wdata = '0;
		end
	end

	// restoring divide step, one quotient bit per cycle
	always_comb begin
		dvs  = {{8{1'b0}}, top_q} << k_q;
		fits = rem_q >= dvs;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			last_q <= in_last;
			bin_q  <= dheq_pkg::bin_of(in_depth);
		end
	end

	// sweep index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.sw_start) begin
			idx_q <= dheq_pkg::ADDR_W'(1);
		end else if (cmd.clr_wr || cmd.sw_wr) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// running sum and top of histogram
	always_ff @(posedge clk) begin
		if (cmd.sw_start) begin
			prev_q <= '0;
		end else if (cmd.sw_wr) begin
			prev_q <= acc_sat;
			if (idx_q == dheq_pkg::TOP_BIN) begin
				top_q <= acc_sat;
			end
		end
	end

	// numerator and divider
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rem_q  <= ({{8{1'b0}}, rdata} << 8) - {{8{1'b0}}, rdata};
			quot_q <= '0;
			k_q    <= 3'd7;
		end else if (cmd.div_step) begin
			if (fits) begin
				rem_q       <= rem_q - dvs;
				quot_q[k_q] <= 1'b1;
			end
			k_q <= k_q - 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_q || cmd.out_zero) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_q || cmd.out_zero) begin
			olevel_q <= cmd.out_zero ? '0 : quot_q;
			olast_q  <= last_q;
		end
	end

	assign rsp.valid    = ovalid_q;
	assign rsp.level    = olevel_q;
	assign rsp.last_out = olast_q;

	// status
	always_comb begin
		sts.last     = last_q;
		sts.idx_last = idx_q == dheq_pkg::TOP_BIN;
		sts.zero_map = (bin_q == '0) || (top_q == '0);
		sts.div_done = k_q == 3'd0;
		sts.out_busy = ovalid_q && !rsp.ready;
	end

endmodule

>>> rtl/core/dheq_ctrl.sv
module dheq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_type,
	output logic                in_ready,
	input  dheq_pkg::dheq_sts_t sts,
	output dheq_pkg::dheq_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_SW_RD,
		ST_SW_WR,
		ST_MAP_CHK,
		ST_MAP_MUL,
		ST_DIV,
		ST_OUT,
		ST_OUT_Z
	} state_t;

	state_t state_q;
	logic   pend_q;   // count item waits for the clearing pass
	logic   ready_q;  // bins hold the running sum

	logic   accept;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_wr = 1'b1;
			end
			ST_IDLE: begin
				cmd.latch   = accept;
				cmd.idx_clr = accept && (in_type == dheq_pkg::REQ_COUNT) && ready_q;
			end
			ST_CNT_RD, ST_MAP_CHK: begin
				// bin read runs off the captured address
				cmd = '0;
			end
			ST_CNT_WR: begin
				cmd.cnt_wr   = 1'b1;
				cmd.sw_start = sts.last;
			end
			ST_SW_RD: begin
				cmd.sw_rd = 1'b1;
			end
			ST_SW_WR: begin
				cmd.sw_wr = 1'b1;
			end
			ST_MAP_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_OUT: begin
				cmd.out_q   = !sts.out_busy;
				cmd.idx_clr = !sts.out_busy && sts.last;
			end
			ST_OUT_Z: begin
				cmd.out_zero = !sts.out_busy;
				cmd.idx_clr  = !sts.out_busy && sts.last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state, pending count and counts-ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			pend_q  <= 1'b0;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					if (sts.idx_last) begin
						state_q <= pend_q ? ST_CNT_RD : ST_IDLE;
						pend_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_type == dheq_pkg::REQ_COUNT) begin
							if (ready_q) begin
								state_q <= ST_CLR;
								pend_q  <= 1'b1;
								ready_q <= 1'b0;
							end else begin
								state_q <= ST_CNT_RD;
							end
						end else begin
							state_q <= ST_MAP_CHK;
						end
					end
				end
				ST_CNT_RD: begin
					state_q <= ST_CNT_WR;
				end
				ST_CNT_WR: begin
					state_q <= sts.last ? ST_SW_RD : ST_IDLE;
				end
				ST_SW_RD: begin
					state_q <= ST_SW_WR;
				end
				ST_SW_WR: begin
					if (sts.idx_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end else begin
						state_q <= ST_SW_RD;
					end
				end
				ST_MAP_CHK: begin
					state_q <= (!ready_q || sts.zero_map) ? ST_OUT_Z : ST_MAP_MUL;
				end
				ST_MAP_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT, ST_OUT_Z: begin
					if (!sts.out_busy) begin
						if (sts.last) begin
							state_q <= ST_CLR;
							ready_q <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_CLR;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/depth_histogram_equalizer_unit.sv
// channel | dir | payload                       | handshake
// req     | in  | req_type, depth, last_pixel   | valid / ready
// rsp     | out | level, last_out               | valid / ready
//
// count pixel: bin read, then write back; a last count pixel adds the
//   running-sum sweep over the bin memory, a read and a write per bin (65535 bins)
// map pixel: a zero result skips the multiply; otherwise it runs the 8-step divider
// reset and each last map pixel start a clearing pass over all 65536 bins, one
//   bin a cycle through the single write port; a count pixel after the sweep
//   runs that pass before it is counted; no item is taken meanwhile
// the result sits in an output register; a stalled rsp holds the next map item
module depth_histogram_equalizer_unit (
	input  logic      clk,
	input  logic      arst_n,
	dheq_in_if.sink   req,
	dheq_out_if.source rsp
);

	dheq_pkg::dheq_cmd_t cmd;
	dheq_pkg::dheq_sts_t sts;

	dheq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_type  (req.req_type),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dheq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_depth (req.depth),
		.in_last  (req.last_pixel),
		.rsp      (rsp)
	);

endmodule

>>> sim/dheq_tb_pkg.sv
`timescale 1ns / 100ps
package dheq_tb_pkg;

	import dheq_pkg::*;

	// one expected level item on the rsp channel
	typedef struct {
		logic [LEVEL_W-1:0] level;
		logic               last_out;
	} level_item_t;

endpackage

>>> sim/tb_depth_histogram_equalizer_unit.sv
`timescale 1ns / 100ps
module tb_depth_histogram_equalizer_unit;

	import dheq_pkg::*;
	import dheq_tb_pkg::*;

	logic clk;
	logic arst_n;

	dheq_in_if  req_if ();
	dheq_out_if rsp_if ();

	depth_histogram_equalizer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow histogram, holds counts or running sums like the block
	logic [CNT_W-1:0] hist [DEPTH_BINS];
	logic             hist_summed;
	level_item_t      levels_due [$];
	int unsigned      fail_count;
	int unsigned      burst_left;
	logic [15:0]      stall_pattern;
	logic             rsp_free;
	int unsigned      rsp_cyc;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void clear_hist();
		for (int i = 0; i < DEPTH_BINS; i++) begin
			hist[i] = '0;
		end
		hist_summed = 1'b0;
	endfunction

	// running sum from bin 1 upward, saturating
	function automatic void sum_hist();
		logic [CNT_W:0] s;
		for (int i = 2; i < DEPTH_BINS; i++) begin
			s = {1'b0, hist[i]} + {1'b0, hist[i-1]};
			hist[i] = (s > CNT_MAX) ? CNT_MAX : s[CNT_W-1:0];
		end
		hist_summed = 1'b1;
	endfunction

	// update the shadow state for one accepted item, queue the level if any
	function automatic void predict_level(logic rt, logic [DEPTH_W-1:0] d, logic lst);
		logic [ADDR_W-1:0] b;
		logic [63:0]       top;
		logic [63:0]       q;
		level_item_t       e;
		b = (32'(d) >= DEPTH_BINS) ? ADDR_W'(DEPTH_BINS - 1) : ADDR_W'(d);
		if (rt == REQ_COUNT) begin
			if (hist_summed) clear_hist();
			if (hist[b] < CNT_MAX) hist[b] = hist[b] + 1'b1;
			if (lst) sum_hist();
		end else begin
			top = 64'(hist[DEPTH_BINS-1]);
			q = 0;
			if (hist_summed && b != 0 && top != 0) begin
				q = (64'(hist[b]) * 255) / top;
				if (q > 255) q = 255;
			end
			e.level = q[LEVEL_W-1:0];
			e.last_out = lst;
			levels_due.push_back(e);
			if (lst) clear_hist();
		end
	endfunction

	// send one pixel item, bursts with random gaps
	task automatic send_pixel(logic rt, logic [DEPTH_W-1:0] d, logic lst);
		int unsigned gap;
		req_if.valid <= 1'b1;
		req_if.req_type <= rt;
		req_if.depth <= d;
		req_if.last_pixel <= lst;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		predict_level(rt, d, lst);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	function automatic logic [DEPTH_W-1:0] rand_depth();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return DEPTH_W'($urandom_range(1, 16));
			2: return DEPTH_W'($urandom_range(60000, 65535));
			default: return DEPTH_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// map pixels before any sweep give zero, last one still clears
	task automatic test_map_before_sweep();
		send_pixel(REQ_MAP, 16'd500, 1'b0);
		send_pixel(REQ_MAP, 16'hFFFF, 1'b0);
		send_pixel(REQ_MAP, 16'd0, 1'b1);
	endtask

	// frame of zero depths only, top sum is zero
	task automatic test_empty_sum();
		send_pixel(REQ_COUNT, 16'd0, 1'b0);
		send_pixel(REQ_COUNT, 16'd0, 1'b0);
		send_pixel(REQ_COUNT, 16'd0, 1'b1);
		send_pixel(REQ_MAP, 16'hFFFF, 1'b0);
		send_pixel(REQ_MAP, 16'd1, 1'b0);
		send_pixel(REQ_MAP, 16'd0, 1'b1);
	endtask

	// extremes, then a count pixel drops the pending map pass
	task automatic test_new_frame_abandons_map();
		send_pixel(REQ_COUNT, 16'd1, 1'b0);
		send_pixel(REQ_COUNT, 16'hFFFF, 1'b0);
		send_pixel(REQ_COUNT, 16'd0, 1'b0);
		send_pixel(REQ_COUNT, 16'd1, 1'b0);
		send_pixel(REQ_COUNT, 16'h8000, 1'b0);
		send_pixel(REQ_COUNT, 16'h5555, 1'b0);
		send_pixel(REQ_COUNT, 16'hAAAA, 1'b1);
		send_pixel(REQ_MAP, 16'd0, 1'b0);
		send_pixel(REQ_MAP, 16'd1, 1'b0);
		send_pixel(REQ_MAP, 16'd2, 1'b0);
		send_pixel(REQ_MAP, 16'h7FFF, 1'b0);
		send_pixel(REQ_MAP, 16'hAAAA, 1'b0);
		send_pixel(REQ_MAP, 16'hFFFF, 1'b0);
		send_pixel(REQ_COUNT, 16'd3, 1'b0);
	endtask

	// full frame: count pass then map pass over mostly counted depths
	task automatic test_random_frame(int unsigned n);
		logic [DEPTH_W-1:0] seen [$];
		logic [DEPTH_W-1:0] d;
		for (int i = 0; i < n; i++) begin
			d = rand_depth();
			seen.push_back(d);
			// stray map pixel mid count pass gives zero
			if ($urandom_range(0, 40) == 0) send_pixel(REQ_MAP, rand_depth(), 1'b0);
			send_pixel(REQ_COUNT, d, i == n - 1);
		end
		for (int i = 0; i < n; i++) begin
			d = ($urandom_range(0, 3) == 0) ? rand_depth()
				: seen[$urandom_range(0, seen.size() - 1)];
			send_pixel(REQ_MAP, d, i == n - 1);
		end
	endtask

	// receiver stall pattern, with free-running stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_pattern <= 16'hB5C3;
			rsp_free <= 1'b0;
			rsp_cyc <= 0;
		end else begin
			rsp_cyc <= rsp_cyc + 1;
			if (rsp_cyc % 200 == 199) begin
				stall_pattern <= 16'($urandom());
				rsp_free <= ($urandom_range(0, 2) == 0);
			end
			rsp_if.ready <= rsp_free | stall_pattern[rsp_cyc % 16];
		end
	end

	// level checker
	always @(posedge clk) begin
		level_item_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (levels_due.size() == 0) begin
				$display("%0t: unexpected level item: level=%0d last_out=%0b",
					$time, rsp_if.level, rsp_if.last_out);
				fail_count++;
			end else begin
				e = levels_due.pop_front();
				if (rsp_if.level !== e.level) begin
					$display("%0t: level mismatch: expected %0d, actual %0d",
						$time, e.level, rsp_if.level);
					fail_count++;
				end
				if (rsp_if.last_out !== e.last_out) begin
					$display("%0t: last_out mismatch: expected %0b, actual %0b",
						$time, e.last_out, rsp_if.last_out);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int unsigned waited;
		fail_count = 0;
		burst_left = 0;
		clear_hist();
		req_if.valid = 1'b0;
		req_if.req_type = REQ_COUNT;
		req_if.depth = '0;
		req_if.last_pixel = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_map_before_sweep();
		test_empty_sum();
		test_new_frame_abandons_map();
		test_random_frame(155);
		test_random_frame(155);
		req_if.valid <= 1'b0;

		waited = 0;
		while (levels_due.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		// trailing clearing pass after the last map pixel
		repeat (66000) @(posedge clk);
		if (fail_count == 0 && levels_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
